// ===== hdl/ctl_pkg.sv =====
// Package: token kinds, lexer modes, error codes and character-class helpers.
package ctl_pkg;

  localparam int LengthBits = 16;
  localparam int LineBits   = 24;
  localparam int ColBits    = 16;
  localparam int KindBits   = 6;
  localparam int ErrBits    = 3;
  localparam int MaxTokens  = 3;

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_PUNCT    = 4'd1,
    M_LINECMT  = 4'd2,
    M_BLOCKCMT = 4'd3,
    M_NUMBER   = 4'd4,
    M_IDENT    = 4'd5,
    M_CHAR     = 4'd6,
    M_STRING   = 4'd7
  } lex_mode_e;

  localparam logic [KindBits-1:0] K_EOF      = 6'd0;
  localparam logic [KindBits-1:0] K_RBRACKET = 6'd5;
  localparam logic [KindBits-1:0] K_LBRACE   = 6'd6;
  localparam logic [KindBits-1:0] K_RBRACE   = 6'd7;
  localparam logic [KindBits-1:0] K_LBRACKET = 6'd4;
  localparam logic [KindBits-1:0] K_ELLIPSIS = 6'd14;
  localparam logic [KindBits-1:0] K_DOT      = 6'd15;
  localparam logic [KindBits-1:0] K_HASHHASH = 6'd33;
  localparam logic [KindBits-1:0] K_HASH     = 6'd34;
  localparam logic [KindBits-1:0] K_LLEQ     = 6'd36;
  localparam logic [KindBits-1:0] K_LL       = 6'd37;
  localparam logic [KindBits-1:0] K_GGEQ     = 6'd41;
  localparam logic [KindBits-1:0] K_GG       = 6'd42;
  localparam logic [KindBits-1:0] K_NUMBER   = 6'd49;
  localparam logic [KindBits-1:0] K_UNKNOWN  = 6'd50;
  localparam logic [KindBits-1:0] K_CHAR     = 6'd51;
  localparam logic [KindBits-1:0] K_STRING   = 6'd52;
  localparam logic [KindBits-1:0] K_IDENT    = 6'd53;
  localparam logic [KindBits-1:0] K_NONE     = 6'd63;

  localparam logic [ErrBits-1:0] E_NONE      = 3'd0;
  localparam logic [ErrBits-1:0] E_BLOCKCMT  = 3'd1;
  localparam logic [ErrBits-1:0] E_EMPTYCHAR = 3'd2;
  localparam logic [ErrBits-1:0] E_CHAR      = 3'd3;
  localparam logic [ErrBits-1:0] E_STRING    = 3'd4;

  localparam logic [7:0] C_NUL = 8'h00;
  localparam logic [7:0] C_LF  = 8'h0A;
  localparam logic [7:0] C_CR  = 8'h0D;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [LineBits-1:0]   line;
    logic [ColBits-1:0]    col;
    logic [LengthBits-1:0] len;
    logic [ErrBits-1:0]    err;
  } token_t;

  // one step's worth of tokens, slot 0 first
  typedef struct packed {
    logic [MaxTokens-1:0] valid;
    token_t [MaxTokens-1:0] tok;
  } token_group_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [KindBits-1:0] lone_kind(input logic [7:0] c);
    case (c)
      "?": return 6'd1;
      "(": return 6'd2;
      ")": return 6'd3;
      "[": return 6'd4;
      "]": return 6'd5;
      "{": return 6'd6;
      "}": return 6'd7;
      "~": return 6'd8;
      ";": return 6'd9;
      ",": return 6'd10;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [KindBits-1:0] short_kind(input logic [7:0] c);
    case (c)
      ":": return 6'd11;
      "=": return 6'd13;
      ".": return K_DOT;
      "&": return 6'd18;
      "*": return 6'd20;
      "+": return 6'd23;
      "-": return 6'd27;
      "!": return 6'd29;
      "/": return 6'd31;
      "%": return 6'd35;
      "<": return 6'd39;
      ">": return 6'd43;
      "^": return 6'd45;
      "|": return 6'd48;
      "#": return K_HASH;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [KindBits-1:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [KindBits-1:0] k;
    k = K_NONE;
    case (h)
      ":": if (c == ">") k = K_RBRACKET;
      "=": if (c == "=") k = 6'd12;
      "&": if (c == "&") k = 6'd16; else if (c == "=") k = 6'd17;
      "*": if (c == "=") k = 6'd19;
      "+": if (c == "+") k = 6'd21; else if (c == "=") k = 6'd22;
      "-": if (c == "-") k = 6'd24; else if (c == ">") k = 6'd25;
           else if (c == "=") k = 6'd26;
      "!": if (c == "=") k = 6'd28;
      "/": if (c == "=") k = 6'd30;
      "%": if (c == "=") k = 6'd32; else if (c == ">") k = K_RBRACE;
      "<": if (c == "=") k = 6'd38; else if (c == ":") k = K_LBRACKET;
           else if (c == "%") k = K_LBRACE;
      ">": if (c == "=") k = 6'd40;
      "^": if (c == "=") k = 6'd44;
      "|": if (c == "=") k = 6'd46; else if (c == "|") k = 6'd47;
      "#": if (c == "#") k = K_HASHHASH;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/c_token_lexer.sv =====
// C token lexer top level: byte stream in, token stream out.
// Usage:
//   s_axis carries one source byte per transaction in s_axis_tdata_i; a byte of
//   zero ends the input and yields an EOF token, after which a new stream may
//   follow with line and column continuing.
//   m_axis carries one token per transaction. tdata packs kind, start line,
//   start column, length and error code; tlast marks the final token caused by
//   one input byte. A byte may cause zero to three tokens.
//   Tokens of a byte are registered into the queue as the byte is taken and
//   are offered once earlier tokens have gone. Throughput: one byte per cycle
//   while each byte yields at most one token and the receiver takes each one;
//   a byte with several tokens hands them out in turn. The lexer state
//   advances on the byte itself, so a two-entry token-group queue decouples
//   the sides; s_axis_tready drops only when both are full. When the receiver
//   stalls, tokens hold and input is taken until the queue fills. Reset
//   clears the lexer to idle, line 1, column 1, and empties the queue.
module c_token_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [5:0] kind [29:6] line [45:30] col
                                      // [61:46] length [64:62] error, rest zero
  output logic        m_axis_tlast
);
  import ctl_pkg::*;

  logic         step;
  token_group_t group;
  token_t       tok;

  assign step = s_axis_tvalid && s_axis_tready;

  ctl_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .char_i  (s_axis_tdata),
    .group_o (group)
  );

  ctl_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .group_i (group),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .tok_o   (tok),
    .last_o  (m_axis_tlast),
    .take_i  (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, tok.err, tok.len, tok.col, tok.line, tok.kind};

endmodule

// ===== hdl/ctl_core.sv =====
// Lexer state and the per-byte token decision: one byte in, up to three tokens out.
module ctl_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            char_i,
  output ctl_pkg::token_group_t group_o
);
  import ctl_pkg::*;

  lex_mode_e             mode_q, mode_d;
  logic [7:0]            held0_q, held0_d;
  logic [1:0]            held_cnt_q, held_cnt_d;
  logic [7:0]            prev_q, prev_d;
  logic                  esc_q, esc_d;
  logic [LineBits-1:0]   line_q, line_d;
  logic [ColBits-1:0]    col_q, col_d;
  logic [LineBits-1:0]   sline_q, sline_d;
  logic [ColBits-1:0]    scol_q, scol_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic                  cerr_q, cerr_d;

  localparam logic [LengthBits-1:0] LenTop  = '1;
  localparam logic [ColBits-1:0]    ColTop  = '1;
  localparam logic [LineBits-1:0]   LineTop = '1;

  function automatic logic [LengthBits-1:0] len_up(input logic [LengthBits-1:0] v);
    return (v == LenTop) ? v : v + 1'b1;
  endfunction

  function automatic logic [ColBits-1:0] col_up(input logic [ColBits-1:0] v);
    return (v == ColTop) ? v : v + 1'b1;
  endfunction

  function automatic logic [LengthBits-1:0] len_of(input int unsigned n);
    return LengthBits'(n);
  endfunction

  always_comb begin
    logic [7:0]          c;
    logic [KindBits-1:0] k;
    logic [1:0]          n;
    logic                quote;
    logic                restart;   // run the start step on rs_c at rs_line/rs_col
    logic [7:0]          rs_c;
    logic [LineBits-1:0] rs_line;
    logic [ColBits-1:0]  rs_col;
    logic                refeed;    // after a restarted held byte, feed c again
    logic                fin;

    c = char_i;
    k = K_NONE;
    n = '0;
    group_o = '0;
    mode_d = mode_q; held0_d = held0_q; held_cnt_d = held_cnt_q; prev_d = prev_q;
    esc_d = esc_q; sline_d = sline_q; scol_d = scol_q; len_d = len_q; cerr_d = cerr_q;
    restart = 1'b0; rs_c = c; rs_line = line_q; rs_col = col_q; refeed = 1'b0;
    quote = (mode_q == M_CHAR);
    fin = 1'b0;

    // first phase: the current mode sees the byte
    unique case (mode_q)
      M_PUNCT: begin
        if (held_cnt_q == 2'd1) begin
          if (held0_q == "." && is_digit(c)) begin
            mode_d = M_NUMBER; len_d = len_up(len_q); prev_d = c; held_cnt_d = 2'd0;
          end else if (held0_q == "/" && c == "/") begin
            mode_d = M_LINECMT; held_cnt_d = 2'd0;
          end else if (held0_q == "/" && c == "*") begin
            mode_d = M_BLOCKCMT; prev_d = C_NUL; held_cnt_d = 2'd0;
          end else if ((held0_q == "." && c == ".") || (held0_q == "%" && c == ":") ||
                       (held0_q == "<" && c == "<") || (held0_q == ">" && c == ">")) begin
            held_cnt_d = 2'd2; len_d = len_of(2);
          end else if (pair_kind(held0_q, c) != K_NONE) begin
            group_o.valid[n] = 1'b1;
            group_o.tok[n] = '{pair_kind(held0_q, c), sline_q, scol_q, len_of(2), E_NONE};
            n = n + 2'd1; fin = 1'b1;
          end else begin
            k = short_kind(held0_q);
            group_o.valid[n] = 1'b1;
            group_o.tok[n] = '{(k == K_NONE) ? K_UNKNOWN : k, sline_q, scol_q, len_of(1),
                               E_NONE};
            n = n + 2'd1; restart = 1'b1;
          end
        end else if (held_cnt_q == 2'd2) begin
          if (held0_q == ".") begin
            group_o.valid[n] = 1'b1;
            if (c == ".") begin
              group_o.tok[n] = '{K_ELLIPSIS, sline_q, scol_q, len_of(3), E_NONE};
              fin = 1'b1;
            end else begin
              group_o.tok[n] = '{K_DOT, sline_q, scol_q, len_of(1), E_NONE};
              restart = 1'b1; rs_c = "."; rs_line = sline_q; rs_col = col_up(scol_q);
              refeed = 1'b1;
            end
            n = n + 2'd1;
          end else if (held0_q == "%") begin
            if (c == "%") begin
              held_cnt_d = 2'd3; len_d = len_of(3);
            end else begin
              group_o.valid[n] = 1'b1;
              group_o.tok[n] = '{K_HASH, sline_q, scol_q, len_of(2), E_NONE};
              n = n + 2'd1; restart = 1'b1;
            end
          end else begin
            group_o.valid[n] = 1'b1;
            if (c == "=") begin
              group_o.tok[n] = '{(held0_q == "<") ? K_LLEQ : K_GGEQ, sline_q, scol_q,
                                 len_of(3), E_NONE};
              fin = 1'b1;
            end else begin
              group_o.tok[n] = '{(held0_q == "<") ? K_LL : K_GG, sline_q, scol_q,
                                 len_of(2), E_NONE};
              restart = 1'b1;
            end
            n = n + 2'd1;
          end
        end else if (held_cnt_q == 2'd3) begin
          group_o.valid[n] = 1'b1;
          if (c == ":") begin
            group_o.tok[n] = '{K_HASHHASH, sline_q, scol_q, len_of(4), E_NONE};
            fin = 1'b1;
          end else begin
            group_o.tok[n] = '{K_HASH, sline_q, scol_q, len_of(2), E_NONE};
            restart = 1'b1; rs_c = "%"; rs_line = sline_q; rs_col = col_up(col_up(scol_q));
            refeed = 1'b1;
          end
          n = n + 2'd1;
        end else begin
          restart = 1'b1;
        end
      end
      M_LINECMT: begin
        if (c == C_LF) mode_d = M_IDLE;
        else if (c == C_NUL) restart = 1'b1;
      end
      M_BLOCKCMT: begin
        if (c == C_NUL) begin
          cerr_d = 1'b1; restart = 1'b1;
        end else if (c == "/" && prev_q == "*") begin
          mode_d = M_IDLE;
        end else begin
          prev_d = c;
        end
      end
      M_NUMBER: begin
        if (is_digit(c) || is_alpha(c) || c == "." ||
            ((c == "+" || c == "-") &&
             (prev_q == "e" || prev_q == "E" || prev_q == "p" || prev_q == "P"))) begin
          len_d = len_up(len_q); prev_d = c;
        end else begin
          group_o.valid[n] = 1'b1;
          group_o.tok[n] = '{K_NUMBER, sline_q, scol_q, len_q, E_NONE};
          n = n + 2'd1; restart = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_digit(c) || is_alpha(c) || c == "_") begin
          len_d = len_up(len_q);
        end else begin
          group_o.valid[n] = 1'b1;
          group_o.tok[n] = '{K_IDENT, sline_q, scol_q, len_q, E_NONE};
          n = n + 2'd1; restart = 1'b1;
        end
      end
      M_CHAR, M_STRING: begin
        if (esc_q) begin
          if (c == C_NUL) begin
            group_o.valid[n] = 1'b1;
            group_o.tok[n] = '{K_UNKNOWN, sline_q, scol_q, len_q, quote ? E_CHAR : E_STRING};
            n = n + 2'd1; restart = 1'b1;
          end else begin
            esc_d = 1'b0; len_d = len_up(len_q);
          end
        end else if (c == (quote ? 8'h27 : 8'h22)) begin
          group_o.valid[n] = 1'b1;
          if (quote && len_q == len_of(1))
            group_o.tok[n] = '{K_UNKNOWN, sline_q, scol_q, len_of(2), E_EMPTYCHAR};
          else
            group_o.tok[n] = '{quote ? K_CHAR : K_STRING, sline_q, scol_q, len_up(len_q),
                               E_NONE};
          n = n + 2'd1; fin = 1'b1;
        end else if (c == 8'h5C) begin
          esc_d = 1'b1; len_d = len_up(len_q);
        end else if (c == C_LF || c == C_CR || c == C_NUL) begin
          group_o.valid[n] = 1'b1;
          group_o.tok[n] = '{K_UNKNOWN, sline_q, scol_q, len_q, quote ? E_CHAR : E_STRING};
          n = n + 2'd1; restart = 1'b1;
        end else begin
          len_d = len_up(len_q);
        end
      end
      default: restart = 1'b1;
    endcase

    if (fin) begin
      mode_d = M_IDLE; held_cnt_d = 2'd0; esc_d = 1'b0;
    end

    // second phase: start a token on the restarted byte
    if (restart) begin
      mode_d = M_IDLE; held_cnt_d = 2'd0; esc_d = 1'b0;
      sline_d = rs_line; scol_d = rs_col; len_d = len_of(1);
      if (rs_c == C_NUL) begin
        group_o.valid[n] = 1'b1;
        group_o.tok[n] = '{K_EOF, rs_line, rs_col, len_of(0),
                           cerr_d ? E_BLOCKCMT : E_NONE};
        n = n + 2'd1; cerr_d = 1'b0;
      end else if (is_space(rs_c)) begin
        mode_d = M_IDLE;
      end else if (lone_kind(rs_c) != K_NONE) begin
        group_o.valid[n] = 1'b1;
        group_o.tok[n] = '{lone_kind(rs_c), rs_line, rs_col, len_of(1), E_NONE};
        n = n + 2'd1;
      end else if (short_kind(rs_c) != K_NONE) begin
        mode_d = M_PUNCT; held0_d = rs_c; held_cnt_d = 2'd1;
      end else if (rs_c == 8'h27) begin
        mode_d = M_CHAR;
      end else if (rs_c == 8'h22) begin
        mode_d = M_STRING;
      end else if (is_alpha(rs_c) || rs_c == "_") begin
        mode_d = M_IDENT;
      end else if (is_digit(rs_c)) begin
        mode_d = M_NUMBER; prev_d = rs_c;
      end else begin
        group_o.valid[n] = 1'b1;
        group_o.tok[n] = '{K_UNKNOWN, rs_line, rs_col, len_of(1), E_NONE};
        n = n + 2'd1;
      end
    end

    // third phase: a re-lexed held byte ('.' or '%') now sees c with one held byte
    if (refeed) begin
      if (rs_c == "." && is_digit(c)) begin
        mode_d = M_NUMBER; len_d = len_of(2); prev_d = c; held_cnt_d = 2'd0;
      end else if (rs_c == "." && c == ".") begin
        held_cnt_d = 2'd2; len_d = len_of(2);
      end else if (rs_c == "%" && c == ":") begin
        held_cnt_d = 2'd2; len_d = len_of(2);
      end else if (pair_kind(rs_c, c) != K_NONE) begin
        group_o.valid[n] = 1'b1;
        group_o.tok[n] = '{pair_kind(rs_c, c), rs_line, rs_col, len_of(2), E_NONE};
        n = n + 2'd1;
        mode_d = M_IDLE; held_cnt_d = 2'd0;
      end else begin
        group_o.valid[n] = 1'b1;
        group_o.tok[n] = '{short_kind(rs_c), rs_line, rs_col, len_of(1), E_NONE};
        n = n + 2'd1;
        mode_d = M_IDLE; held_cnt_d = 2'd0; sline_d = line_q; scol_d = col_q;
        len_d = len_of(1);
        if (c == C_NUL) begin
          group_o.valid[n] = 1'b1;
          group_o.tok[n] = '{K_EOF, line_q, col_q, len_of(0), cerr_q ? E_BLOCKCMT : E_NONE};
          n = n + 2'd1; cerr_d = 1'b0;
        end else if (is_space(c)) begin
          mode_d = M_IDLE;
        end else if (lone_kind(c) != K_NONE) begin
          group_o.valid[n] = 1'b1;
          group_o.tok[n] = '{lone_kind(c), line_q, col_q, len_of(1), E_NONE};
          n = n + 2'd1;
        end else if (short_kind(c) != K_NONE) begin
          mode_d = M_PUNCT; held0_d = c; held_cnt_d = 2'd1;
        end else if (c == 8'h27) begin
          mode_d = M_CHAR;
        end else if (c == 8'h22) begin
          mode_d = M_STRING;
        end else if (is_alpha(c) || c == "_") begin
          mode_d = M_IDENT;
        end else if (is_digit(c)) begin
          mode_d = M_NUMBER; prev_d = c;
        end else begin
          group_o.valid[n] = 1'b1;
          group_o.tok[n] = '{K_UNKNOWN, line_q, col_q, len_of(1), E_NONE};
          n = n + 2'd1;
        end
      end
    end

    // position counters
    line_d = line_q; col_d = col_q;
    if (c == C_LF) begin
      line_d = (line_q == LineTop) ? line_q : line_q + 1'b1;
      col_d  = ColBits'(1);
    end else if (c != C_NUL) begin
      col_d = col_up(col_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; held0_q <= '0; held_cnt_q <= '0; prev_q <= '0; esc_q <= 1'b0;
      line_q <= LineBits'(1); col_q <= ColBits'(1);
      sline_q <= LineBits'(1); scol_q <= ColBits'(1);
      len_q <= '0; cerr_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; held0_q <= held0_d; held_cnt_q <= held_cnt_d; prev_q <= prev_d;
      esc_q <= esc_d; line_q <= line_d; col_q <= col_d; sline_q <= sline_d;
      scol_q <= scol_d; len_q <= len_d; cerr_q <= cerr_d;
    end
  end

`ifndef SYNTHESIS
  a_held_only_punct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_cnt_q != 2'd0) |-> (mode_q == M_PUNCT)) else $error("held bytes outside punct");
  a_esc_in_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (mode_q == M_CHAR || mode_q == M_STRING)) else $error("escape outside literal");
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q != '0) && (col_q != '0)) else $error("position counter hit zero");
  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (group_o.valid == 3'b000 || group_o.valid == 3'b001 ||
                group_o.valid == 3'b011 || group_o.valid == 3'b111))
    else $error("token slots not packed");
`endif

endmodule

// ===== hdl/ctl_outq.sv =====
// Output queue: holds two token groups; one token leaves per cycle when taken.
module ctl_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ctl_pkg::token_group_t group_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output ctl_pkg::token_t       tok_o,
  output logic                  last_o,
  input  logic                  take_i
);
  import ctl_pkg::*;

  // two group slots so a new byte can land while the old group drains
  token_group_t     grp_q [2];
  logic [MaxTokens-1:0] pend_q [2];
  logic             rd_q, wr_q;
  logic [MaxTokens-1:0] cur;
  logic [1:0]       idx;
  logic [MaxTokens-1:0] rest;

  assign cur = pend_q[rd_q];
  always_comb begin
    idx = 2'd0;
    if (!cur[0]) idx = cur[1] ? 2'd1 : 2'd2;
    rest = cur;
    rest[idx] = 1'b0;
  end
  assign valid_o = (cur != '0);
  assign tok_o   = grp_q[rd_q].tok[idx];
  assign last_o  = (rest == '0);
  assign ready_o = (pend_q[wr_q] == '0);

  always_ff @(posedge clk_i) begin
    if (load_i && group_i.valid != '0) grp_q[wr_q] <= group_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q[0] <= '0; pend_q[1] <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (valid_o && take_i) begin
        pend_q[rd_q] <= rest;
        if (rest == '0) rd_q <= ~rd_q;
      end
      if (load_i && group_i.valid != '0) begin
        pend_q[wr_q] <= group_i.valid;
        wr_q <= ~wr_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && group_i.valid != '0) |-> ready_o) else $error("group slot overwritten");
  a_last_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && take_i && last_o) |=> (rd_q != $past(rd_q))) else $error("read slot stuck");
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q[rd_q] == '0) |-> (pend_q[~rd_q] == '0)) else $error("slots out of order");
`endif

endmodule

// ===== sim/c_token_lexer_tb.sv =====
// Testbench for the C token lexer: byte stream in, token stream checked against a predictor.
module c_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctl_pkg::*;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic [2:0]  err;
    logic        last;
  } tok_rec_t;

  localparam logic [5:0] K_QUEST = 6'd1;
  localparam logic [5:0] K_LPAREN = 6'd2, K_RPAREN = 6'd3, K_TILDE = 6'd8;
  localparam logic [5:0] K_SEMI = 6'd9, K_COMMA = 6'd10, K_COLON = 6'd11;
  localparam logic [5:0] K_EQEQ = 6'd12, K_EQ = 6'd13, K_ANDAND = 6'd16;
  localparam logic [5:0] K_ANDEQ = 6'd17, K_AND = 6'd18, K_STAREQ = 6'd19;
  localparam logic [5:0] K_STAR = 6'd20, K_INC = 6'd21, K_PLUSEQ = 6'd22;
  localparam logic [5:0] K_PLUS = 6'd23, K_DEC = 6'd24, K_ARROW = 6'd25;
  localparam logic [5:0] K_MINUSEQ = 6'd26, K_MINUS = 6'd27, K_NE = 6'd28;
  localparam logic [5:0] K_NOT = 6'd29, K_DIVEQ = 6'd30, K_DIV = 6'd31;
  localparam logic [5:0] K_MODEQ = 6'd32, K_MOD = 6'd35, K_LE = 6'd38;
  localparam logic [5:0] K_LT = 6'd39, K_GE = 6'd40, K_GT = 6'd43;
  localparam logic [5:0] K_XOREQ = 6'd44, K_XOR = 6'd45, K_OREQ = 6'd46;
  localparam logic [5:0] K_OROR = 6'd47, K_OR = 6'd48;
  localparam int WatchLimit = 4000;

  class token_scoreboard;
    tok_rec_t pending[$];
    int errors;
    int matched;
    lex_mode_e mode;
    logic [7:0] held0, held1, prev_byte;
    int held_n;
    bit esc, cmt_err;
    logic [23:0] line_no, tok_line;
    logic [15:0] col_no, tok_col, len_cnt;
    tok_rec_t step_toks[$];

    function new();
      errors = 0; matched = 0; clear();
    endfunction

    function void clear();
      mode = M_IDLE; held0 = 0; held1 = 0; prev_byte = 0; held_n = 0;
      esc = 0; cmt_err = 0; line_no = 1; col_no = 1; tok_line = 1;
      tok_col = 1; len_cnt = 0;
    endfunction

    function logic [15:0] inc16(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic [5:0] single_kind(logic [7:0] c);
      case (c)
        "?": return K_QUEST; "(": return K_LPAREN; ")": return K_RPAREN;
        "[": return K_LBRACKET; "]": return K_RBRACKET; "{": return K_LBRACE;
        "}": return K_RBRACE; "~": return K_TILDE; ";": return K_SEMI;
        ",": return K_COMMA;
        default: return K_NONE;
      endcase
    endfunction

    function logic [5:0] alone_kind(logic [7:0] c);
      case (c)
        ":": return K_COLON; "=": return K_EQ; ".": return K_DOT;
        "&": return K_AND; "*": return K_STAR; "+": return K_PLUS;
        "-": return K_MINUS; "!": return K_NOT; "/": return K_DIV;
        "%": return K_MOD; "<": return K_LT; ">": return K_GT;
        "^": return K_XOR; "|": return K_OR; "#": return K_HASH;
        default: return K_NONE;
      endcase
    endfunction

    function logic [5:0] two_kind(logic [7:0] h, logic [7:0] c);
      case ({h, c})
        {":", ">"}: return K_RBRACKET; {"=", "="}: return K_EQEQ;
        {"&", "&"}: return K_ANDAND; {"&", "="}: return K_ANDEQ;
        {"*", "="}: return K_STAREQ; {"+", "+"}: return K_INC;
        {"+", "="}: return K_PLUSEQ; {"-", "-"}: return K_DEC;
        {"-", ">"}: return K_ARROW; {"-", "="}: return K_MINUSEQ;
        {"!", "="}: return K_NE; {"/", "="}: return K_DIVEQ;
        {"%", "="}: return K_MODEQ; {"%", ">"}: return K_RBRACE;
        {"<", "="}: return K_LE; {"<", ":"}: return K_LBRACKET;
        {"<", "%"}: return K_LBRACE; {">", "="}: return K_GE;
        {"^", "="}: return K_XOREQ; {"|", "="}: return K_OREQ;
        {"|", "|"}: return K_OROR; {"#", "#"}: return K_HASHHASH;
        default: return K_NONE;
      endcase
    endfunction

    function void push(logic [5:0] k, logic [23:0] ln, logic [15:0] cl,
                       logic [15:0] n, logic [2:0] e);
      tok_rec_t t;
      t.kind = k; t.line = ln; t.col = cl; t.len = n; t.err = e; t.last = 0;
      if (step_toks.size() < MaxTokens) step_toks.insert(step_toks.size(), t);
    endfunction

    function void close_tok(logic [5:0] k, logic [15:0] n, logic [2:0] e);
      push(k, tok_line, tok_col, n, e);
      mode = M_IDLE; held_n = 0; esc = 0;
    endfunction

    function void begin_tok(logic [7:0] c, logic [23:0] ln, logic [15:0] cl);
      mode = M_IDLE; held_n = 0; esc = 0;
      tok_line = ln; tok_col = cl; len_cnt = 1;
      if (c == C_NUL) begin
        push(K_EOF, ln, cl, 0, cmt_err ? E_BLOCKCMT : E_NONE);
        cmt_err = 0;
        return;
      end
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      if (single_kind(c) != K_NONE) begin
        close_tok(single_kind(c), 1, E_NONE);
      end else if (alone_kind(c) != K_NONE) begin
        mode = M_PUNCT; held0 = c; held_n = 1;
      end else if (c == "'") begin
        mode = M_CHAR;
      end else if (c == "\"") begin
        mode = M_STRING;
      end else if (alpha(c) || c == "_") begin
        mode = M_IDENT;
      end else if (digit(c)) begin
        mode = M_NUMBER; prev_byte = c;
      end else begin
        close_tok(K_UNKNOWN, 1, E_NONE);
      end
    endfunction

    function void lex(logic [7:0] c, logic [23:0] ln, logic [15:0] cl);
      logic [7:0] h;
      logic [23:0] sl;
      logic [15:0] sc;
      logic [5:0] k;
      bit q;
      h = held0; sl = tok_line; sc = tok_col;
      case (mode)
        M_PUNCT: begin
          if (held_n == 1) begin
            if (h == "." && digit(c)) begin
              mode = M_NUMBER; len_cnt = inc16(len_cnt); prev_byte = c; held_n = 0;
            end else if (h == "/" && c == "/") begin
              mode = M_LINECMT; held_n = 0;
            end else if (h == "/" && c == "*") begin
              mode = M_BLOCKCMT; prev_byte = 0; held_n = 0;
            end else if ((h == "." && c == ".") || (h == "%" && c == ":") ||
                         (h == "<" && c == "<") || (h == ">" && c == ">")) begin
              held1 = c; held_n = 2; len_cnt = 2;
            end else begin
              k = two_kind(h, c);
              if (k != K_NONE) close_tok(k, 2, E_NONE);
              else begin
                close_tok(alone_kind(h), 1, E_NONE);
                begin_tok(c, ln, cl);
              end
            end
          end else if (held_n == 2) begin
            case (h)
              ".": if (c == ".") close_tok(K_ELLIPSIS, 3, E_NONE);
                else begin
                  close_tok(K_DOT, 1, E_NONE);
                  begin_tok(".", sl, inc16(sc));
                  lex(c, ln, cl);
                end
              "%": if (c == "%") begin
                  held_n = 3; len_cnt = 3;
                end else begin
                  close_tok(K_HASH, 2, E_NONE); begin_tok(c, ln, cl);
                end
              "<": if (c == "=") close_tok(K_LLEQ, 3, E_NONE);
                else begin
                  close_tok(K_LL, 2, E_NONE); begin_tok(c, ln, cl);
                end
              default: if (c == "=") close_tok(K_GGEQ, 3, E_NONE);
                else begin
                  close_tok(K_GG, 2, E_NONE); begin_tok(c, ln, cl);
                end
            endcase
          end else if (held_n == 3) begin
            if (c == ":") close_tok(K_HASHHASH, 4, E_NONE);
            else begin
              close_tok(K_HASH, 2, E_NONE);
              begin_tok("%", sl, inc16(inc16(sc)));
              lex(c, ln, cl);
            end
          end else begin
            begin_tok(c, ln, cl);
          end
        end
        M_LINECMT: begin
          if (c == C_LF) mode = M_IDLE;
          else if (c == C_NUL) begin_tok(c, ln, cl);
        end
        M_BLOCKCMT: begin
          if (c == C_NUL) begin
            cmt_err = 1; begin_tok(c, ln, cl);
          end else if (c == "/" && prev_byte == "*") mode = M_IDLE;
          else prev_byte = c;
        end
        M_NUMBER: begin
          if (digit(c) || alpha(c) || c == "." ||
              ((c == "+" || c == "-") && (prev_byte == "e" || prev_byte == "E" ||
               prev_byte == "p" || prev_byte == "P"))) begin
            len_cnt = inc16(len_cnt); prev_byte = c;
          end else begin
            close_tok(K_NUMBER, len_cnt, E_NONE); begin_tok(c, ln, cl);
          end
        end
        M_IDENT: begin
          if (digit(c) || alpha(c) || c == "_") len_cnt = inc16(len_cnt);
          else begin
            close_tok(K_IDENT, len_cnt, E_NONE); begin_tok(c, ln, cl);
          end
        end
        M_CHAR, M_STRING: begin
          q = (mode == M_CHAR);
          if (esc) begin
            if (c == C_NUL) begin
              close_tok(K_UNKNOWN, len_cnt, q ? E_CHAR : E_STRING);
              begin_tok(c, ln, cl);
            end else begin
              esc = 0; len_cnt = inc16(len_cnt);
            end
          end else if (c == (q ? 8'h27 : 8'h22)) begin
            if (q && len_cnt == 1) close_tok(K_UNKNOWN, 2, E_EMPTYCHAR);
            else close_tok(q ? K_CHAR : K_STRING, inc16(len_cnt), E_NONE);
          end else if (c == "\\") begin
            esc = 1; len_cnt = inc16(len_cnt);
          end else if (c == C_LF || c == C_CR || c == C_NUL) begin
            close_tok(K_UNKNOWN, len_cnt, q ? E_CHAR : E_STRING);
            begin_tok(c, ln, cl);
          end else begin
            len_cnt = inc16(len_cnt);
          end
        end
        default: begin_tok(c, ln, cl);
      endcase
    endfunction

    // predict the tokens of one accepted byte
    function void note_byte(logic [7:0] c);
      step_toks.delete();
      lex(c, line_no, col_no);
      if (c == C_LF) begin
        line_no = (line_no == 24'hFFFFFF) ? line_no : line_no + 24'd1;
        col_no = 1;
      end else if (c != C_NUL) begin
        col_no = inc16(col_no);
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1;
      foreach (step_toks[i]) pending.insert(pending.size(), step_toks[i]);
    endfunction

    function void check_token(logic [71:0] data, logic last, output string msg);
      tok_rec_t e;
      msg = "";
      if (pending.size() == 0) begin
        msg = $sformatf("token with no expectation: %h", data);
        return;
      end
      e = pending.pop_front();
      if (data[5:0] != e.kind || data[29:6] != e.line || data[45:30] != e.col ||
          data[61:46] != e.len || data[64:62] != e.err || data[71:65] != 0 ||
          last != e.last)
        msg = $sformatf("got kind %0d ln %0d col %0d len %0d err %0d last %0b, want %0d %0d %0d %0d %0d %0b",
                        data[5:0], data[29:6], data[45:30], data[61:46], data[64:62], last,
                        e.kind, e.line, e.col, e.len, e.err, e.last);
      else matched++;
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [71:0] m_axis_tdata;

  c_token_lexer dut (.*);

  token_scoreboard board = new();
  logic [7:0] src_bytes[$];
  bit quiet_phase = 0;
  bit hold_sink = 0;
  bit feed_done = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  initial forever #4 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    board.errors++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src_bytes.insert(src_bytes.size(), s[i]);
  endtask

  // sender: walk the byte queue, with random gaps
  task automatic drive_bytes();
    int gap;
    while (src_bytes.size() > 0) begin
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1;
      s_axis_tdata <= src_bytes[0];
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      void'(src_bytes.pop_front());
    end
    s_axis_tvalid <= 0;
  endtask

  // receiver: random stalls, plus the long hold-off when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (60) @(posedge clk_i);
        hold_sink = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1;
        @(posedge clk_i);
      end
    end
  end

  // monitor: note accepted bytes and check accepted tokens
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_token(m_axis_tdata, m_axis_tlast, msg);
        if (msg != "") report(msg);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    wait (idle_cycles >= WatchLimit);
    $display("timeout after %0d quiet cycles", WatchLimit);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    string alphabet;
    alphabet = "?()[]{}~;,:=.&*+-!/%<>^|#'\"\\_aeEpPxz09 \t\n\r";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'h00;
      default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endcase
  endfunction

  // random C-like fragment, some holding malformed literals
  task automatic add_fragment();
    string frags[$];
    frags = '{"int x1 = 0x1Fp+3;", "a->b++ -= c", "s = \"q\\\"\\n\";", "c='\\'';",
              "/* c * / */ y", "// note\n", "1.5e-7f ", "<<= >>= ... %:%:", "<: :> <% %>",
              "a&&b||!c", "x ^= y|=z", "'ab", "\"open\n", ".5 .. .x", "%:%x", "#define Q_1 ##"};
    add_text(frags[$urandom_range(0, frags.size() - 1)]);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: digraphs, long prefixes, literals, comments, stray bytes
    add_text("%:%:%:%x..y...<<=>>a\n");
    add_text("'' 'a\n\"s\\");
    src_bytes.insert(src_bytes.size(), 8'h00);
    src_bytes.insert(src_bytes.size(), 8'hFF);
    add_text("/*x*");
    src_bytes.insert(src_bytes.size(), 8'h00);
    add_text("9e+1@`$");
    src_bytes.insert(src_bytes.size(), 8'h80);
    src_bytes.insert(src_bytes.size(), 8'h7F);
    src_bytes.insert(src_bytes.size(), 8'h01);
    bytes_sent += src_bytes.size();
    drive_bytes();

    // pressure: stall the receiver while punctuators flood in
    hold_sink = 1;
    repeat (40) src_bytes.insert(src_bytes.size(), pick_byte() == 0 ? ";" : ",");
    bytes_sent += src_bytes.size();
    drive_bytes();
    wait (!hold_sink);

    while (bytes_sent < 180) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) src_bytes.insert(src_bytes.size(), pick_byte());
      end else begin
        add_fragment();
      end
      bytes_sent += src_bytes.size();
      if (bytes_sent > 140) quiet_phase = 1;
      drive_bytes();
    end
    src_bytes.insert(src_bytes.size(), 8'h00);
    drive_bytes();
    feed_done = 1;
  end

  initial begin
    wait (feed_done);
    wait (board.pending.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("fed C fragments, digraphs, literals, comments and stray bytes;");
    $display("%0d tokens matched, %0d mismatches", board.matched, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
